>>> design/cdc_pkg.sv
// Shared constants and inter-stage word types for the day count to civil date converter.
// No dependencies; used by every module of the block.
package cdc_pkg;

    localparam logic [19:0] MaxCount   = 20'd910674;
    // 584693 + 146097 * 82: lands the count on the March-based calendar
    localparam logic [23:0] Offset     = 24'd12564647;
    localparam logic [17:0] CentDiv    = 18'd146097;
    localparam logic [14:0] CentRecip  = 15'd29398;     // floor(2^32 / 146097)
    localparam logic [21:0] YearMul    = 22'd2939745;
    localparam logic [10:0] YearLen    = 11'd1461;
    localparam logic [6:0]  CentYears  = 7'd100;
    localparam logic [11:0] MdMul      = 12'd2141;
    localparam logic [19:0] MdAdd      = 20'd197913;
    localparam logic [15:0] DayRecip   = 16'd62690;     // ceil(2^27 / 2141)
    localparam logic [8:0]  JanFeb     = 9'd306;
    localparam logic [3:0]  MonthsYear = 4'd12;
    localparam logic [15:0] YearBias   = 16'd32800;     // 400 * 82

    typedef struct packed {
        logic        ok;
        logic [8:0]  cent;
        logic [17:0] n2;
    } t_cent_word;

    typedef struct packed {
        logic        ok;
        logic [15:0] yr;
        logic [8:0]  ny;
    } t_year_word;

endpackage

>>> design/cdc_century.sv
// Century stages: offset, division by 146097 via reciprocal, remainder fix-up.
// Depends on cdc_pkg.
module cdc_century
    import cdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  logic [19:0] i_day_count,
    output logic        o_vld,
    input  logic        i_rdy,
    output t_cent_word  o_word
);

    logic        r1_vld, r2_vld, r3_vld;
    logic        en1, en2, en3;
    logic        r1_ok, r2_ok;
    logic [25:0] r1_n1;
    logic [8:0]  r1_q, r2_q;
    logic [18:0] r2_rem;
    t_cent_word  r3_word;

    logic [23:0] n_n;
    logic [25:0] n_n1;
    logic [40:0] n_prod;
    logic [26:0] n_qd;
    logic [25:0] n_rem0;
    logic        n_big;
    logic [18:0] n_rem;
    t_cent_word  n_word;

    assign en3   = !r3_vld || i_rdy;
    assign en2   = !r2_vld || en3;
    assign en1   = !r1_vld || en2;
    assign o_rdy = en1;

    always_comb begin
        n_n    = {4'd0, i_day_count} + Offset;
        n_n1   = {n_n, 2'b11};
        n_prod = {15'd0, n_n1} * {26'd0, CentRecip};
        // quotient estimate may be one short; stage 3 fixes it
        n_qd   = {18'd0, r1_q} * {9'd0, CentDiv};
        n_rem0 = r1_n1 - n_qd[25:0];
        n_big  = r2_rem >= {1'b0, CentDiv};
        n_rem  = n_big ? (r2_rem - {1'b0, CentDiv}) : r2_rem;
        n_word.ok   = r2_ok;
        n_word.cent = r2_q + {8'd0, n_big};
        n_word.n2   = {n_rem[17:2], 2'b11};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (en1) r1_vld <= i_vld;
            if (en2) r2_vld <= r1_vld;
            if (en3) r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_ok <= (i_day_count != 20'd0) && (i_day_count <= MaxCount);
            r1_n1 <= n_n1;
            r1_q  <= n_prod[40:32];
        end
        if (en2) begin
            r2_ok  <= r1_ok;
            r2_q   <= r1_q;
            r2_rem <= n_rem0[18:0];
        end
        if (en3) begin
            r3_word <= n_word;
        end
    end

    assign o_vld  = r3_vld;
    assign o_word = r3_word;

endmodule

>>> design/cdc_year.sv
// Year-within-century stages: 2939745 multiply split at bit 32, day of year.
// Depends on cdc_pkg.
module cdc_year
    import cdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    output logic       o_rdy,
    input  t_cent_word i_word,
    output logic       o_vld,
    input  logic       i_rdy,
    output t_year_word o_word
);

    logic        r4_vld, r5_vld;
    logic        en4, en5;
    logic        r4_ok;
    logic [6:0]  r4_z;
    logic [17:0] r4_n2;
    logic [8:0]  r4_cent;
    t_year_word  r5_word;

    logic [39:0] n_p2;
    logic [17:0] n_zl;
    logic [17:0] n_r;
    logic [15:0] n_yc;
    t_year_word  n_word;

    assign en5   = !r5_vld || i_rdy;
    assign en4   = !r4_vld || en5;
    assign o_rdy = en4;

    always_comb begin
        n_p2 = {22'd0, i_word.n2} * {18'd0, YearMul};
        // low word / 2939745 equals n2 - 1461*z exactly over the whole range
        n_zl = {11'd0, r4_z} * {7'd0, YearLen};
        n_r  = r4_n2 - n_zl;
        n_yc = {7'd0, r4_cent} * {9'd0, CentYears};
        n_word.ok = r4_ok;
        n_word.yr = n_yc + {9'd0, r4_z};
        n_word.ny = n_r[10:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            if (en4) r4_vld <= i_vld;
            if (en5) r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_ok   <= i_word.ok;
            r4_z    <= n_p2[38:32];
            r4_n2   <= i_word.n2;
            r4_cent <= i_word.cent;
        end
        if (en5) begin
            r5_word <= n_word;
        end
    end

    assign o_vld  = r5_vld;
    assign o_word = r5_word;

endmodule

>>> design/cdc_month_day.sv
// Month/day stages: 2141/65536 affine step, day by reciprocal, Jan/Feb year fix.
// Depends on cdc_pkg; holds the block's output register.
module cdc_month_day
    import cdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  t_year_word  i_word,
    output logic        o_vld,
    input  logic        i_rdy,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic        o_valid_res
);

    logic        r6_vld, r7_vld;
    logic        en6, en7;
    logic        r6_ok, r6_jf;
    logic [19:0] r6_n3;
    logic [15:0] r6_yr;
    logic [11:0] r7_year;
    logic [3:0]  r7_month;
    logic [4:0]  r7_day;
    logic        r7_ok;

    logic [20:0] n_n3;
    logic [31:0] n_dp;
    logic [3:0]  n_mo;
    logic [15:0] n_year;

    assign en7   = !r7_vld || i_rdy;
    assign en6   = !r6_vld || en7;
    assign o_rdy = en6;

    always_comb begin
        n_n3   = {12'd0, i_word.ny} * {9'd0, MdMul} + {1'b0, MdAdd};
        // exact floor(x / 2141) for any 16-bit x
        n_dp   = {16'd0, r6_n3[15:0]} * {16'd0, DayRecip};
        n_mo   = r6_n3[19:16];
        n_year = r6_yr + {15'd0, r6_jf} - YearBias;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else begin
            if (en6) r6_vld <= i_vld;
            if (en7) r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_ok <= i_word.ok;
            r6_jf <= i_word.ny >= JanFeb;
            r6_n3 <= n_n3[19:0];
            r6_yr <= i_word.yr;
        end
        if (en7) begin
            r7_ok <= r6_ok;
            if (r6_ok) begin
                r7_year  <= n_year[11:0];
                r7_month <= r6_jf ? (n_mo - MonthsYear) : n_mo;
                r7_day   <= n_dp[31:27] + 5'd1;
            end else begin
                r7_year  <= 12'd0;
                r7_month <= 4'd0;
                r7_day   <= 5'd0;
            end
        end
    end

    assign o_vld          = r7_vld;
    assign o_year         = r7_year;
    assign o_month        = r7_month;
    assign o_day_of_month = r7_day;
    assign o_valid_res    = r7_ok;

endmodule

>>> design/day_count_to_civil_date.sv
// Day count to proleptic Gregorian date: a seven-stage pipeline that takes one
// day count (1 = first of January 1601) per cycle when not stalled and gives
// year, month and day of month; counts of zero or above 910674 give an all-zero
// date with o_valid_res low. There are three stages on the century path
// (reciprocal multiply, back-multiply and subtract, remainder fix-up), two for
// the year (2939745 multiply, then day of year and century scaling) and two for
// month and day (2141 affine step, then day reciprocal and Jan/Feb year fix),
// each ending in a register. Every stage has its own valid and a ready chain, so
// bubbles close up under back-pressure and a stall loses no word.
// Depends on cdc_pkg, cdc_century, cdc_year and cdc_month_day.
module day_count_to_civil_date
    import cdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_day_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic        o_valid_res
);

    t_cent_word cent_word;
    t_year_word year_word;
    logic       cent_vld, cent_rdy;
    logic       year_vld, year_rdy;

    cdc_century u_century (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_valid),
        .o_rdy       (o_ready),
        .i_day_count (i_day_count),
        .o_vld       (cent_vld),
        .i_rdy       (cent_rdy),
        .o_word      (cent_word)
    );

    cdc_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cent_vld),
        .o_rdy   (cent_rdy),
        .i_word  (cent_word),
        .o_vld   (year_vld),
        .i_rdy   (year_rdy),
        .o_word  (year_word)
    );

    cdc_month_day u_month_day (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (year_vld),
        .o_rdy          (year_rdy),
        .i_word         (year_word),
        .o_vld          (o_valid),
        .i_rdy          (i_ready),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_valid_res    (o_valid_res)
    );

endmodule
